// ----- rtl/core/pixel_to_ansi_text_encoder_assert.svh -----
// Assertion macros used by the checker of the pixel to ANSI text encoder.
`ifndef PIXEL_TO_ANSI_TEXT_ENCODER_ASSERT_SVH
`define PIXEL_TO_ANSI_TEXT_ENCODER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define P2A_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define P2A_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/p2a_pkg.sv -----
`timescale 1ns / 1ps
// Types, constants and helper functions of the pixel to ANSI text encoder.
package p2a_pkg;

  localparam int unsigned CfgAw = 2;
  localparam int unsigned CfgDw = 8;

  typedef enum logic [CfgAw-1:0] {
    CFG_COLOR_MODE   = 2'd0,
    CFG_ROW_WIDTH    = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_idx_e;

  localparam logic [1:0] ModeAnsi = 2'd1;
  localparam logic [1:0] ModeTrue = 2'd2;

  localparam logic [1:0] ResetColorMode   = 2'd0;
  localparam logic [7:0] ResetRowWidth    = 8'd120;
  localparam logic [6:0] ResetFrameHeight = 7'd60;

  typedef enum logic [1:0] {
    KIND_GRAY,
    KIND_ANSI,
    KIND_TRUE
  } job_kind_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] gray;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       frame_end;
  } text_t;

  // Decimal split of one 8-bit value: digit[0] hundreds, [1] tens, [2] ones;
  // first is the position of the leading printed digit.
  typedef struct packed {
    logic [2:0][3:0] digit;
    logic [1:0]      first;
  } dec_t;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] glyph;
    logic [3:0] code_hi;
    logic [3:0] code_lo;
    dec_t [2:0] chan;
    logic       newline;
    logic       frame_end;
  } job_t;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QIdxW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // (r+g+b)/3 and x/10 by reciprocal multiply
  localparam int unsigned Div3Mul    = 683;
  localparam int unsigned Div3Shift  = 11;
  localparam int unsigned Div10Mul   = 205;
  localparam int unsigned Div10Shift = 11;

  localparam logic [7:0] DarkLimit   = 8'd30;
  localparam logic [7:0] GrayBand    = 8'd20;
  localparam logic [7:0] WhiteLimit  = 8'd200;
  localparam logic [7:0] LightLimit  = 8'd120;
  localparam logic [7:0] BrightLimit = 8'd128;

  localparam logic [7:0] CharEsc  = 8'h1B;
  localparam logic [7:0] CharLbr  = 8'h5B;
  localparam logic [7:0] CharM    = 8'h6D;
  localparam logic [7:0] CharSemi = 8'h3B;
  localparam logic [7:0] CharNl   = 8'h0A;
  localparam logic [7:0] CharZero = 8'h30;

  localparam int unsigned PfxLen = 5;
  localparam int unsigned RstLen = 4;
  localparam logic [7:0] TRUE_PFX [PfxLen] = '{8'h33, 8'h38, 8'h3B, 8'h32, 8'h3B};
  localparam logic [7:0] RST_SEQ  [RstLen] = '{8'h1B, 8'h5B, 8'h30, 8'h6D};

  localparam int unsigned GlyphSteps = 9;
  // smallest level with level*9/255 >= k, for k = 1..9
  localparam logic [7:0] GLYPH_THR [GlyphSteps] =
    '{8'd29, 8'd57, 8'd85, 8'd114, 8'd142, 8'd170, 8'd199, 8'd227, 8'd255};
  localparam logic [7:0] GLYPH_RAMP [GlyphSteps+1] =
    '{8'h40, 8'h25, 8'h23, 8'h2A, 8'h2B, 8'h3D, 8'h2D, 8'h3A, 8'h2E, 8'h20};

  function automatic logic [7:0] glyph_of(input logic [7:0] lvl);
    logic [3:0] idx;
    idx = '0;
    for (int k = 0; k < GlyphSteps; k++) begin
      if (lvl >= GLYPH_THR[k]) idx = idx + 4'd1;
    end
    return GLYPH_RAMP[idx];
  endfunction

  function automatic dec_t dec_split(input logic [7:0] v);
    dec_t        res;
    logic [1:0]  hun;
    logic [7:0]  rem;
    logic [15:0] prod;
    logic [3:0]  tens;
    logic [7:0]  ones;
    if (v >= 8'd200) hun = 2'd2;
    else if (v >= 8'd100) hun = 2'd1;
    else hun = 2'd0;
    rem  = v - ((hun == 2'd2) ? 8'd200 : (hun == 2'd1) ? 8'd100 : 8'd0);
    prod = 16'(rem) * 16'(Div10Mul);
    tens = prod[Div10Shift +: 4];
    ones = rem - ({4'b0, tens} * 8'd10);
    res.digit[0] = {2'b0, hun};
    res.digit[1] = tens;
    res.digit[2] = ones[3:0];
    if (v >= 8'd100) res.first = 2'd0;
    else if (v >= 8'd10) res.first = 2'd1;
    else res.first = 2'd2;
    return res;
  endfunction

endpackage

// ----- rtl/core/p2a_fifo.sv -----
`timescale 1ns / 1ps
// Short job queue between the classifying front and the byte sequencer.
module p2a_fifo import p2a_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_vld_o,
  output job_t head_job_o
);

  job_t             slot_q [QDepth];
  logic [QIdxW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QIdxW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == QCntW'(QDepth));
  assign head_vld_o = (cnt_q != '0);
  assign head_job_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QIdxW'(QDepth - 1)) ? '0 : wr_ptr_q + QIdxW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QIdxW'(QDepth - 1)) ? '0 : rd_ptr_q + QIdxW'(1);
    end
    if (push_i && !pop_i) cnt_d = cnt_q + QCntW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - QCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_job_i;
  end

endmodule

// ----- rtl/core/p2a_front.sv -----
`timescale 1ns / 1ps
// Front end: configuration, row and frame tracking, pixel classification into jobs.
module p2a_front import p2a_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pixel_t           in_pixel_i,
  input  logic             cfg_we_i,
  input  logic [CfgAw-1:0] cfg_idx_i,
  input  logic [CfgDw-1:0] cfg_wdata_i,
  output logic             push_o,
  output job_t             push_job_o,
  input  logic             full_i
);

  logic [1:0] mode_q;
  logic [7:0] row_width_q;
  logic [6:0] frame_height_q;
  logic [7:0] col_q, col_d;
  logic [6:0] row_q, row_d;

  logic       stg_vld_q, stg_vld_d;
  pixel_t     stg_pix_q;
  logic [7:0] stg_avg_q;
  job_kind_e  stg_kind_q, kind_d;
  logic       stg_nl_q, nl_d;
  logic       stg_fe_q, fe_d;

  logic        accept;
  logic [9:0]  sum;
  logic [19:0] avg_prod;
  logic [8:0]  col_next;
  logic [7:0]  row_next;

  assign in_stall_o = stg_vld_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = stg_vld_q && !full_i;

  assign sum      = 10'(in_pixel_i.red) + 10'(in_pixel_i.green) + 10'(in_pixel_i.blue);
  assign avg_prod = 20'(sum) * 20'(Div3Mul);
  assign col_next = {1'b0, col_q} + 9'd1;
  assign row_next = {1'b0, row_q} + 8'd1;

  always_comb begin
    nl_d  = (col_next >= {1'b0, row_width_q});
    fe_d  = nl_d && (row_next >= {1'b0, frame_height_q});
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      col_d = nl_d ? '0 : col_next[7:0];
      if (nl_d) row_d = fe_d ? '0 : row_next[6:0];
    end
    if (mode_q == ModeAnsi) kind_d = KIND_ANSI;
    else if (mode_q == ModeTrue) kind_d = KIND_TRUE;
    else kind_d = KIND_GRAY;
    stg_vld_d = stg_vld_q;
    if (accept) stg_vld_d = 1'b1;
    else if (push_o) stg_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= ResetColorMode;
      row_width_q    <= ResetRowWidth;
      frame_height_q <= ResetFrameHeight;
      col_q          <= '0;
      row_q          <= '0;
      stg_vld_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_COLOR_MODE:   mode_q         <= cfg_wdata_i[1:0];
          CFG_ROW_WIDTH:    row_width_q    <= cfg_wdata_i[7:0];
          CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i[6:0];
          default: ;
        endcase
      end
      col_q     <= col_d;
      row_q     <= row_d;
      stg_vld_q <= stg_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_pix_q  <= in_pixel_i;
      stg_avg_q  <= avg_prod[Div3Shift +: 8];
      stg_kind_q <= kind_d;
      stg_nl_q   <= nl_d;
      stg_fe_q   <= fe_d;
    end
  end

  // Classification of the staged pixel
  logic [7:0] mx, mn, spread;
  logic       bright;
  logic [3:0] hi, lo;
  logic       r_top, g_top, b_top;

  always_comb begin
    mx = stg_pix_q.red;
    if (stg_pix_q.green > mx) mx = stg_pix_q.green;
    if (stg_pix_q.blue > mx) mx = stg_pix_q.blue;
    mn = stg_pix_q.red;
    if (stg_pix_q.green < mn) mn = stg_pix_q.green;
    if (stg_pix_q.blue < mn) mn = stg_pix_q.blue;
    spread = mx - mn;
    bright = stg_avg_q > BrightLimit;
    r_top  = (stg_pix_q.red > stg_pix_q.green) && (stg_pix_q.red > stg_pix_q.blue);
    g_top  = (stg_pix_q.green > stg_pix_q.red) && (stg_pix_q.green > stg_pix_q.blue);
    b_top  = (stg_pix_q.blue > stg_pix_q.red) && (stg_pix_q.blue > stg_pix_q.green);
    priority if (stg_avg_q < DarkLimit) begin
      hi = 4'd3; lo = 4'd0;
    end else if (spread < GrayBand) begin
      if (stg_avg_q > WhiteLimit) begin
        hi = 4'd9; lo = 4'd7;
      end else if (stg_avg_q > LightLimit) begin
        hi = 4'd3; lo = 4'd7;
      end else begin
        hi = 4'd9; lo = 4'd0;
      end
    end else if (r_top) begin
      hi = bright ? 4'd9 : 4'd3; lo = 4'd1;
    end else if (g_top) begin
      hi = bright ? 4'd9 : 4'd3; lo = 4'd2;
    end else if (b_top) begin
      hi = bright ? 4'd9 : 4'd3; lo = 4'd4;
    end else begin
      hi = 4'd3; lo = 4'd7;
    end
  end

  always_comb begin
    push_job_o.kind      = stg_kind_q;
    push_job_o.glyph     = glyph_of((stg_kind_q == KIND_GRAY) ? stg_pix_q.gray : stg_avg_q);
    push_job_o.code_hi   = hi;
    push_job_o.code_lo   = lo;
    push_job_o.chan[0]   = dec_split(stg_pix_q.red);
    push_job_o.chan[1]   = dec_split(stg_pix_q.green);
    push_job_o.chan[2]   = dec_split(stg_pix_q.blue);
    push_job_o.newline   = stg_nl_q;
    push_job_o.frame_end = stg_fe_q;
  end

endmodule

// ----- rtl/core/p2a_back.sv -----
`timescale 1ns / 1ps
// Back end: walks the head job and emits its text one byte per cycle while the output is not stalled.
module p2a_back import p2a_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  head_vld_i,
  input  job_t  head_job_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output text_t out_text_o
);

  typedef enum logic [3:0] {
    SQ_HEAD, SQ_LBR, SQ_CODE, SQ_PFX, SQ_DEC, SQ_SEP, SQ_M, SQ_GLYPH, SQ_RST, SQ_NL
  } seq_e;

  seq_e       seq_q, seq_d, eff;
  logic [2:0] sub_q, sub_d;
  logic [1:0] ch_q, ch_d, ch_nxt;
  logic       out_vld_q;
  text_t      out_q;

  logic       fire, done;
  logic [7:0] txt_byte;

  assign fire        = head_vld_i && (!out_vld_q || !out_stall_i);
  assign pop_o       = fire && done;
  assign out_valid_o = out_vld_q;
  assign out_text_o  = out_q;
  assign ch_nxt      = ch_q + 2'd1;

  always_comb begin
    eff = seq_q;
    if (seq_q == SQ_HEAD && head_job_i.kind == KIND_GRAY) eff = SQ_GLYPH;
    txt_byte = CharEsc;
    done     = 1'b0;
    seq_d    = seq_q;
    sub_d    = sub_q;
    ch_d     = ch_q;
    unique case (eff)
      SQ_HEAD: begin
        txt_byte = CharEsc;
        seq_d    = SQ_LBR;
      end
      SQ_LBR: begin
        txt_byte = CharLbr;
        sub_d    = '0;
        seq_d    = (head_job_i.kind == KIND_ANSI) ? SQ_CODE : SQ_PFX;
      end
      SQ_CODE: begin
        txt_byte = CharZero + {4'b0, (sub_q == 3'd0) ? head_job_i.code_hi : head_job_i.code_lo};
        if (sub_q == 3'd0) sub_d = 3'd1;
        else seq_d = SQ_M;
      end
      SQ_PFX: begin
        txt_byte = TRUE_PFX[sub_q];
        if (sub_q == 3'(PfxLen - 1)) begin
          seq_d = SQ_DEC;
          ch_d  = '0;
          sub_d = {1'b0, head_job_i.chan[0].first};
        end else begin
          sub_d = sub_q + 3'd1;
        end
      end
      SQ_DEC: begin
        txt_byte = CharZero + {4'b0, head_job_i.chan[ch_q].digit[sub_q[1:0]]};
        if (sub_q[1:0] == 2'd2) seq_d = (ch_q == 2'd2) ? SQ_M : SQ_SEP;
        else sub_d = sub_q + 3'd1;
      end
      SQ_SEP: begin
        txt_byte = CharSemi;
        ch_d     = ch_nxt;
        sub_d    = {1'b0, head_job_i.chan[ch_nxt].first};
        seq_d    = SQ_DEC;
      end
      SQ_M: begin
        txt_byte = CharM;
        seq_d    = SQ_GLYPH;
      end
      SQ_GLYPH: begin
        txt_byte = head_job_i.glyph;
        if (head_job_i.kind != KIND_GRAY) begin
          seq_d = SQ_RST;
          sub_d = '0;
        end else if (head_job_i.newline) begin
          seq_d = SQ_NL;
        end else begin
          done = 1'b1;
        end
      end
      SQ_RST: begin
        txt_byte = RST_SEQ[sub_q[1:0]];
        if (sub_q[1:0] == 2'(RstLen - 1)) begin
          if (head_job_i.newline) seq_d = SQ_NL;
          else done = 1'b1;
        end else begin
          sub_d = sub_q + 3'd1;
        end
      end
      SQ_NL: begin
        txt_byte = CharNl;
        done     = 1'b1;
      end
      default: begin
        seq_d = SQ_HEAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= SQ_HEAD;
      sub_q     <= '0;
      ch_q      <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else if (fire) begin
      out_vld_q       <= 1'b1;
      out_q.out_byte  <= txt_byte;
      out_q.last      <= done;
      out_q.frame_end <= done && (eff == SQ_NL) && head_job_i.frame_end;
      // restart at the head of the next job once this one is out
      seq_q           <= done ? SQ_HEAD : seq_d;
      sub_q           <= done ? '0 : sub_d;
      ch_q            <= done ? '0 : ch_d;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/pixel_to_ansi_text_encoder.sv -----
`timescale 1ns / 1ps
// Top level of the pixel to ANSI text encoder: front, job queue and byte sequencer.
//
//   channel  direction  handshake                 beat
//   in       sink       in_valid_i / in_stall_o   pixel_t: red, green, blue, gray
//   out      source     out_valid_o / out_stall_i text_t: out_byte, last, frame_end
//   cfg      sink       cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One output byte per cycle while the output is not stalled; a pixel's text is
// 1-2 bytes in gray mode, 10-11 with 16-colour escapes, 18-25 with 24-bit escapes.
// The single output register of the sequencer sets this rate.
// First byte of a pixel passes the front's staging register, a queue slot and the sequencer's output register.
// Reset is asynchronous; the row and column counts clear, configuration registers take their defaults.
// out_stall_i holds the current beat; pixels keep entering while the queue has room.
module pixel_to_ansi_text_encoder import p2a_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pixel_t           in_pixel_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output text_t            out_text_o,
  input  logic             cfg_we_i,
  input  logic [CfgAw-1:0] cfg_idx_i,
  input  logic [CfgDw-1:0] cfg_wdata_i
);

  logic push, full, pop, head_vld;
  job_t push_job, head_job;

  p2a_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_pixel_i  (in_pixel_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (push),
    .push_job_o  (push_job),
    .full_i      (full)
  );

  p2a_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .head_vld_o (head_vld),
    .head_job_o (head_job)
  );

  p2a_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_vld_i  (head_vld),
    .head_job_i  (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_text_o  (out_text_o)
  );

endmodule

// ----- rtl/core/p2a_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker of the pixel to ANSI text encoder and its bind.
`include "pixel_to_ansi_text_encoder_assert.svh"

module p2a_checker import p2a_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  out_valid_i,
  input logic  out_stall_i,
  input text_t out_text_i
);

  logic out_beat;
  assign out_beat = out_valid_i && !out_stall_i;

  `P2A_ASSERT_NEXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i && $stable(out_text_i), "stalled output beat changed")
  `P2A_ASSERT_NOW(a_frame_nl, out_valid_i && out_text_i.frame_end, out_text_i.last && (out_text_i.out_byte == CharNl), "frame end not on a closing newline")
  `P2A_ASSERT_NEXT(a_esc_lbr, out_beat && (out_text_i.out_byte == CharEsc), out_valid_i && (out_text_i.out_byte == CharLbr), "escape not followed by bracket")
  `P2A_ASSERT_NEXT(a_pixel_run, out_beat && !out_text_i.last, out_valid_i, "gap inside the bytes of one pixel")

endmodule

bind pixel_to_ansi_text_encoder p2a_checker u_p2a_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_text_i  (out_text_o)
);
